// ----- hw/rtl/ltde_pkg.sv -----
// ----------------------------------------------------------------------------
// ltde_pkg
// Shared types, constants and the token table for the line token distance
// extractor.
// ----------------------------------------------------------------------------
package ltde_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned IdW       = 8;
  localparam int unsigned DistW     = 16;
  localparam int unsigned AccW      = 17;
  localparam int unsigned ProgW     = 4;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 24;

  localparam int unsigned LineMaxDefault = 512;

  // Token "distance[cm]=" and its length
  localparam logic [ProgW-1:0] TokenLen  = 4'd13;
  localparam logic [AccW-1:0]  ValueSat  = 17'd65536;

  // Character codes
  localparam logic [ByteW-1:0] ChLf    = 8'd10;
  localparam logic [ByteW-1:0] ChCr    = 8'd13;
  localparam logic [ByteW-1:0] ChSpace = 8'd32;
  localparam logic [ByteW-1:0] ChTab   = 8'd9;
  localparam logic [ByteW-1:0] ChVt    = 8'd11;
  localparam logic [ByteW-1:0] ChFf    = 8'd12;
  localparam logic [ByteW-1:0] ChPlus  = 8'd43;
  localparam logic [ByteW-1:0] ChMinus = 8'd45;
  localparam logic [ByteW-1:0] ChZero  = 8'd48;
  localparam logic [ByteW-1:0] ChNine  = 8'd57;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] RegClientId = 2'd0;
  localparam logic [CfgAddrW-1:0] RegMinDist  = 2'd1;
  localparam logic [CfgAddrW-1:0] RegMaxDist  = 2'd2;

  // Configuration reset values
  localparam logic [IdW-1:0]   ClientIdReset = 8'd1;
  localparam logic [DistW-1:0] MinDistReset  = 16'd10;
  localparam logic [DistW-1:0] MaxDistReset  = 16'd400;

  // Number parser phase
  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // One emitted result
  typedef struct packed {
    logic [IdW-1:0]   source_id;
    logic [DistW-1:0] distance_value;
  } result_t;

  // Configuration as seen by the parser
  typedef struct packed {
    logic [IdW-1:0]   station_id;
    logic [DistW-1:0] min_distance;
    logic [DistW-1:0] max_distance;
  } cfg_t;

  // Token character at a match position
  function automatic logic [ByteW-1:0] token_char(input logic [ProgW-1:0] idx);
    logic [ByteW-1:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h64; // d
      4'd1:    ch = 8'h69; // i
      4'd2:    ch = 8'h73; // s
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h61; // a
      4'd5:    ch = 8'h6e; // n
      4'd6:    ch = 8'h63; // c
      4'd7:    ch = 8'h65; // e
      4'd8:    ch = 8'h5b; // [
      4'd9:    ch = 8'h63; // c
      4'd10:   ch = 8'h6d; // m
      4'd11:   ch = 8'h5d; // ]
      4'd12:   ch = 8'h3d; // =
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- hw/rtl/ltde_in_reg.sv -----
// ----------------------------------------------------------------------------
// ltde_in_reg
// Input register stage: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module ltde_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ltde_pkg::ByteW-1:0] s_byte,
  output logic                      hold_valid,
  output logic [ltde_pkg::ByteW-1:0] hold_byte,
  input  logic                      take
);
  import ltde_pkg::*;

  // Free slot, or slot being emptied this cycle
  assign s_tready = !hold_valid || take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_byte <= s_byte;
    end
  end

endmodule

// ----- hw/rtl/ltde_parser.sv -----
// ----------------------------------------------------------------------------
// ltde_parser
// Line state, token matcher and decimal parser; one byte per cycle while step is
// high, flags a result at the end of a qualifying line.
// ----------------------------------------------------------------------------
module ltde_parser #(
  parameter int unsigned LINE_MAX = ltde_pkg::LineMaxDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [ltde_pkg::ByteW-1:0] rx_byte,
  input  ltde_pkg::cfg_t             cfg,
  output logic                       emit,
  output ltde_pkg::result_t          result
);
  import ltde_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_MAX + 1);
  localparam logic [LenW-1:0] LenLimit = LenW'(LINE_MAX);

  logic [LenW-1:0]  line_length, line_length_next;
  logic [ProgW-1:0] token_progress, token_progress_next;
  phase_t           number_phase, number_phase_next;
  logic             negative_flag, negative_flag_next;
  logic [AccW-1:0]  value_accumulator, value_accumulator_next;

  logic             is_term;
  logic             is_blank;
  logic             is_digit;
  logic [20:0]      acc_mul;

  // Character classes
  assign is_term  = (rx_byte == ChLf) || (rx_byte == ChCr);
  assign is_blank = (rx_byte == ChSpace) || (rx_byte == ChTab) ||
                    (rx_byte == ChVt) || (rx_byte == ChFf);
  assign is_digit = (rx_byte >= ChZero) && (rx_byte <= ChNine);

  // acc * 10 + digit, as shifts and adds
  assign acc_mul = {value_accumulator, 3'b000} + {3'b000, value_accumulator, 1'b0}
                 + {13'd0, rx_byte - ChZero};

  // Next state and result flag
  always_comb begin
    line_length_next       = line_length;
    token_progress_next    = token_progress;
    number_phase_next      = number_phase;
    negative_flag_next     = negative_flag;
    value_accumulator_next = value_accumulator;
    emit                   = 1'b0;

    if (is_term) begin
      // End of a non-empty line: judge the value, then start a fresh line
      if (line_length != '0) begin
        if ((token_progress == TokenLen) &&
            !(negative_flag && (value_accumulator != '0)) &&
            (value_accumulator >= {1'b0, cfg.min_distance}) &&
            (value_accumulator <= {1'b0, cfg.max_distance})) begin
          emit = 1'b1;
        end
        line_length_next       = '0;
        token_progress_next    = '0;
        number_phase_next      = PH_LEAD;
        negative_flag_next     = 1'b0;
        value_accumulator_next = '0;
      end
    end else if (line_length >= LenLimit) begin
      // Overlong line: drop byte and line
      line_length_next       = '0;
      token_progress_next    = '0;
      number_phase_next      = PH_LEAD;
      negative_flag_next     = 1'b0;
      value_accumulator_next = '0;
    end else begin
      line_length_next = line_length + LenW'(1);
      if (token_progress == TokenLen) begin
        // Number after the token
        unique case (number_phase)
          PH_DONE: begin
          end
          PH_LEAD: begin
            if (is_blank) begin
            end else if ((rx_byte == ChPlus) || (rx_byte == ChMinus)) begin
              negative_flag_next = (rx_byte == ChMinus);
              number_phase_next  = PH_SIGN;
            end else if (!is_digit) begin
              number_phase_next = PH_DONE;
            end else begin
              number_phase_next      = PH_DIGITS;
              value_accumulator_next = (acc_mul > {4'd0, ValueSat}) ? ValueSat
                                                                     : acc_mul[AccW-1:0];
            end
          end
          default: begin
            if (!is_digit) begin
              number_phase_next = PH_DONE;
            end else begin
              number_phase_next      = PH_DIGITS;
              value_accumulator_next = (acc_mul > {4'd0, ValueSat}) ? ValueSat
                                                                     : acc_mul[AccW-1:0];
            end
          end
        endcase
      end else begin
        // Token matcher, restarting on the first token character
        if (rx_byte == token_char(token_progress)) begin
          token_progress_next = token_progress + ProgW'(1);
        end else if (rx_byte == token_char('0)) begin
          token_progress_next = ProgW'(1);
        end else begin
          token_progress_next = '0;
        end
      end
    end
  end

  assign result.source_id      = cfg.station_id;
  assign result.distance_value = value_accumulator[DistW-1:0];

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length       <= '0;
      token_progress    <= '0;
      number_phase      <= PH_LEAD;
      negative_flag     <= 1'b0;
      value_accumulator <= '0;
    end else if (step) begin
      line_length       <= line_length_next;
      token_progress    <= token_progress_next;
      number_phase      <= number_phase_next;
      negative_flag     <= negative_flag_next;
      value_accumulator <= value_accumulator_next;
    end
  end

endmodule

// ----- hw/rtl/ltde_out_reg.sv -----
// ----------------------------------------------------------------------------
// ltde_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module ltde_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  ltde_pkg::result_t              result,
  output logic                           room,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ltde_pkg::OutTdataW-1:0] m_tdata
);
  import ltde_pkg::*;

  result_t held;

  // Empty, or emptied this cycle
  assign room = !m_tvalid || m_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (room && load) begin
      held <= result;
    end
  end

  assign m_tdata = {held.distance_value, held.source_id};

endmodule

// ----- hw/rtl/line_token_distance_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// line_token_distance_extractor_unit
// Splits a byte stream into lines, finds "distance[cm]=" and emits the client
// id with the parsed distance when it lies within the configured range.
// ----------------------------------------------------------------------------
// A terminator byte's result passes through the input register, then the
// result register, before it shows on m_tvalid.
// Throughput: one byte per cycle; a result held by m_tready low stops the
// parser, and s_tready drops once the input register is full.
// Reset (rst, synchronous): clears line and parse state, empties both
// registers and loads station id 1, min 10, max 400.
// ----------------------------------------------------------------------------
module line_token_distance_extractor_unit #(
  parameter int unsigned LINE_MAX = ltde_pkg::LineMaxDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  // Slave side: tdata [7:0] rx_byte
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ltde_pkg::InTdataW-1:0]  s_tdata,
  // Master side: tdata [7:0] source_id, [23:8] distance_value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ltde_pkg::OutTdataW-1:0] m_tdata,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [ltde_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [ltde_pkg::CfgDataW-1:0]  cfg_wdata
);
  import ltde_pkg::*;

  cfg_t             cfg;
  logic             hold_valid;
  logic [ByteW-1:0] hold_byte;
  logic             room;
  logic             take;
  logic             emit;
  result_t          result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_id   <= ClientIdReset;
      cfg.min_distance <= MinDistReset;
      cfg.max_distance <= MaxDistReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegClientId: cfg.station_id   <= cfg_wdata[IdW-1:0];
        RegMinDist:  cfg.min_distance <= cfg_wdata[DistW-1:0];
        RegMaxDist:  cfg.max_distance <= cfg_wdata[DistW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Byte moves into the parser when the result register can take its outcome
  assign take = hold_valid && room;

  ltde_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_byte     (s_tdata[ByteW-1:0]),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .take       (take)
  );

  ltde_parser #(
    .LINE_MAX (LINE_MAX)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (take),
    .rx_byte (hold_byte),
    .cfg     (cfg),
    .emit    (emit),
    .result  (result)
  );

  ltde_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take && emit),
    .result   (result),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
